/* hw/rtl/class_pool_allocator_fifo_wait_macros.svh */
// assertion macros for the class pool allocator
// no dependencies; included by the files that check their own logic
`ifndef CLASS_POOL_ALLOCATOR_FIFO_WAIT_MACROS_SVH
`define CLASS_POOL_ALLOCATOR_FIFO_WAIT_MACROS_SVH
`ifndef SYNTHESIS
`define CPAFW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define CPAFW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPAFW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define CPAFW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/cpafw_pkg.sv */
// types and fixed constants of the class pool allocator
// no dependencies
`timescale 1ns / 1ps

package cpafw_pkg;

    localparam int NUM_REGS  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 9;
    localparam int WORD_BITS = 16;
    localparam int WORD_SH   = 4;
    localparam int TKT_W     = 8;
    localparam int RID_W     = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RANGE,
        S_DECIDE,
        S_SCAN,
        S_QUEUE,
        S_REL_CHK,
        S_HANDOFF
    } t_state;

    typedef enum logic [1:0] {
        KIND_GRANTED  = 2'd0,
        KIND_QUEUED   = 2'd1,
        KIND_RELEASED = 2'd2,
        KIND_REJECTED = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TKT_W-1:0]   ticket;
        logic [RID_W-1:0]   id;
        logic               last;
    } t_result;

endpackage

/* hw/rtl/cpafw_ram.sv */
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module cpafw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/class_pool_allocator_fifo_wait.sv */
// top level of the class pool allocator with per-class fifo waiters
// depends on cpafw_pkg, cpafw_ram and class_pool_allocator_fifo_wait_macros.svh
//
//   channel   handshake             payload
//   request   start / busy          i_action i_group_size i_resource_id i_ticket
//   result    o_valid (strobe)      o_kind o_ticket_out o_granted_id o_last
//   config    i_cfg_we              i_cfg_idx i_cfg_data
//
// a request walks the class ranges one class per cycle, takes a decide step, then
// scans the taken map one 16-id word per cycle, and queues when no free id lies in
// the class run; a release walks the ranges, decides, then checks the id (an id
// outside the class run is rejected at decide), plus a handoff grant to a waiter.
// a bad class is rejected without going busy. reset and every write to a register
// index below NUM_REGS start a clearing pass over ceil(POOL_SIZE/16) map words
// (16 by default) with busy high.
// results are one-cycle strobes; the receiver cannot stall.
`timescale 1ns / 1ps
`include "class_pool_allocator_fifo_wait_macros.svh"

module class_pool_allocator_fifo_wait
    import cpafw_pkg::*;
#(
    parameter int POOL_SIZE   = 256,
    parameter int WAIT_DEPTH  = 16,
    parameter int NUM_CLASSES = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [2:0]           i_group_size,
    input  logic [RID_W-1:0]     i_resource_id,
    input  logic [TKT_W-1:0]     i_ticket,
    output logic                 o_valid,
    output logic [1:0]           o_kind,
    output logic [TKT_W-1:0]     o_ticket_out,
    output logic [RID_W-1:0]     o_granted_id,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    localparam int MAP_WORDS = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
    localparam int MW_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW0       = MW_W + WORD_SH + 1;
    localparam int CW        = (CW0 > 9) ? CW0 : 9;
    localparam int BW        = $clog2(POOL_SIZE + 1);
    localparam int RW        = (BW > CNT_W) ? BW : CNT_W;
    localparam int CLW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PW        = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WCW       = $clog2(WAIT_DEPTH + 1);
    localparam int WQ_DEPTH  = NUM_CLASSES * WAIT_DEPTH;
    localparam int WAW       = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;

    function automatic logic [WAW-1:0] wq_addr(input logic [CLW-1:0] c,
                                                input logic [PW-1:0] p);
        return WAW'(32'(c) * WAIT_DEPTH + 32'(p));
    endfunction

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt [NUM_REGS];
    logic [BW-1:0]    r_tcnt [NUM_CLASSES];
    logic [PW-1:0]    r_whead [NUM_CLASSES];
    logic [PW-1:0]    r_wtail [NUM_CLASSES];
    logic [WCW-1:0]   r_wcnt [NUM_CLASSES];

    // item and sequencer registers
    logic             r_act;
    logic [CLW-1:0]   r_cls;
    logic [RID_W-1:0] r_rid;
    logic [TKT_W-1:0] r_tkt;
    logic [CLW-1:0]   r_idx, n_idx;
    logic [BW-1:0]    r_base, n_base;
    logic [BW-1:0]    r_len, n_len;
    logic [CW-1:0]    r_end, n_end;
    logic [MW_W-1:0]  r_word, n_word;
    logic [MW_W-1:0]  r_clr, n_clr;
    logic             r_ovalid, n_ovalid;
    t_result          r_res, n_res;

    // per-step controls
    logic             clr_all;
    logic             tc_inc, tc_dec, wq_push, wq_pop;
    logic             map_we;
    logic [MW_W-1:0]  map_waddr, map_raddr;
    logic [WORD_BITS-1:0] map_wdata, map_rdata;
    logic             wq_we;
    logic [WAW-1:0]   wq_waddr, wq_raddr;
    logic [TKT_W-1:0] wq_rdata;

    // shared range unit and scan helpers
    logic [BW-1:0]    room;
    logic [RW-1:0]    cnt_sel;
    logic [BW-1:0]    step_len;
    logic [CW-1:0]    end_v, rid_ext, scan_lo, next_lo;
    logic [WORD_BITS-1:0] free_mask;
    logic [WORD_SH-1:0]   hit_j;
    logic             hit;

    assign clr_all = i_cfg_we && (32'(i_cfg_idx) < NUM_REGS);
    assign busy    = (r_state != S_IDLE);

    cpafw_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    cpafw_ram #(.WIDTH(TKT_W), .DEPTH(WQ_DEPTH)) u_waitq (
        .i_clk   (i_clk),
        .i_we    (wq_we),
        .i_waddr (wq_waddr),
        .i_wdata (r_tkt),
        .i_raddr (wq_raddr),
        .o_rdata (wq_rdata)
    );

    // clipped length of the class under the range walk
    always_comb begin
        room     = BW'(POOL_SIZE) - r_base;
        cnt_sel  = (32'(r_idx) < NUM_REGS) ? RW'(r_cnt[CFG_IDX_W'(r_idx)]) : '0;
        step_len = (cnt_sel > RW'(room)) ? room : BW'(cnt_sel);
        end_v    = CW'(r_base) + CW'(r_len);
        rid_ext  = CW'(r_rid);
        scan_lo  = CW'(r_word) << WORD_SH;
        next_lo  = (CW'(r_word) + 1'b1) << WORD_SH;
    end

    // free ids of the current word that lie inside the class run
    always_comb begin
        free_mask = '0;
        hit_j     = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            free_mask[j] = !map_rdata[j] && (scan_lo + CW'(j) >= CW'(r_base))
                           && (scan_lo + CW'(j) < r_end);
        end
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_mask[j]) begin
                hit_j = WORD_SH'(j);
            end
        end
        hit = |free_mask;
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_base    = r_base;
        n_len     = r_len;
        n_end     = r_end;
        n_word    = r_word;
        n_clr     = r_clr;
        n_ovalid  = 1'b0;
        n_res     = r_res;
        tc_inc    = 1'b0;
        tc_dec    = 1'b0;
        wq_push   = 1'b0;
        wq_pop    = 1'b0;
        map_we    = 1'b0;
        map_waddr = r_word;
        map_wdata = map_rdata;
        map_raddr = '0;
        wq_we     = 1'b0;
        wq_waddr  = wq_addr(r_cls, r_wtail[r_cls]);
        wq_raddr  = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_group_size == 3'd0 || 32'(i_group_size) > NUM_CLASSES) begin
                        n_ovalid = 1'b1;
                        n_res = '{kind: KIND_REJECTED, ticket: i_ticket,
                                  id: (i_action ? i_resource_id : '0), last: 1'b1};
                    end else begin
                        n_idx   = '0;
                        n_base  = '0;
                        n_state = S_RANGE;
                    end
                end
            end
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                map_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == MW_W'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_RANGE: begin
                if (r_idx == r_cls) begin
                    n_len   = step_len;
                    n_state = S_DECIDE;
                end else begin
                    n_base = r_base + step_len;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_DECIDE: begin
                n_end = end_v;
                if (!r_act) begin
                    if (r_len == '0) begin
                        n_ovalid = 1'b1;
                        n_res = '{kind: KIND_REJECTED, ticket: r_tkt, id: '0, last: 1'b1};
                        n_state = S_IDLE;
                    end else if (r_tcnt[r_cls] < r_len) begin
                        map_raddr = MW_W'(r_base >> WORD_SH);
                        n_word    = MW_W'(r_base >> WORD_SH);
                        n_state   = S_SCAN;
                    end else begin
                        n_state = S_QUEUE;
                    end
                end else begin
                    if (rid_ext < CW'(r_base) || rid_ext >= end_v) begin
                        n_ovalid = 1'b1;
                        n_res = '{kind: KIND_REJECTED, ticket: r_tkt, id: r_rid, last: 1'b1};
                        n_state = S_IDLE;
                    end else begin
                        map_raddr = MW_W'(rid_ext >> WORD_SH);
                        n_word    = MW_W'(rid_ext >> WORD_SH);
                        n_state   = S_REL_CHK;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    map_we    = 1'b1;
                    map_wdata = map_rdata | (WORD_BITS'(1) << hit_j);
                    tc_inc    = 1'b1;
                    n_ovalid  = 1'b1;
                    n_res = '{kind: KIND_GRANTED, ticket: r_tkt,
                              id: RID_W'(scan_lo + CW'(hit_j)), last: 1'b1};
                    n_state = S_IDLE;
                end else if (next_lo >= r_end) begin
                    n_state = S_QUEUE;
                end else begin
                    n_word    = r_word + 1'b1;
                    map_raddr = r_word + 1'b1;
                end
            end
            S_QUEUE: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
                if (r_wcnt[r_cls] < WCW'(WAIT_DEPTH)) begin
                    wq_we   = 1'b1;
                    wq_push = 1'b1;
                    n_res = '{kind: KIND_QUEUED, ticket: r_tkt, id: '0, last: 1'b1};
                end else begin
                    n_res = '{kind: KIND_REJECTED, ticket: r_tkt, id: '0, last: 1'b1};
                end
            end
            S_REL_CHK: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
                if (!map_rdata[r_rid[WORD_SH-1:0]]) begin
                    n_res = '{kind: KIND_REJECTED, ticket: r_tkt, id: r_rid, last: 1'b1};
                end else if (r_wcnt[r_cls] != '0) begin
                    // id stays taken and goes to the oldest waiter
                    wq_raddr = wq_addr(r_cls, r_whead[r_cls]);
                    wq_pop   = 1'b1;
                    n_res = '{kind: KIND_RELEASED, ticket: r_tkt, id: r_rid, last: 1'b0};
                    n_state = S_HANDOFF;
                end else begin
                    map_we    = 1'b1;
                    map_wdata = map_rdata & ~(WORD_BITS'(1) << r_rid[WORD_SH-1:0]);
                    tc_dec    = (r_tcnt[r_cls] != '0);
                    n_res = '{kind: KIND_RELEASED, ticket: r_tkt, id: r_rid, last: 1'b1};
                end
            end
            S_HANDOFF: begin
                n_ovalid = 1'b1;
                n_res = '{kind: KIND_GRANTED, ticket: wq_rdata, id: r_rid, last: 1'b1};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a register write moves the ranges: drop everything and sweep the map
        if (clr_all) begin
            n_state  = S_CLEAR;
            n_clr    = '0;
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (clr_all) begin
            r_cnt[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_tcnt[c]  <= '0;
                r_whead[c] <= '0;
                r_wtail[c] <= '0;
                r_wcnt[c]  <= '0;
            end
        end else begin
            if (tc_inc) begin
                r_tcnt[r_cls] <= r_tcnt[r_cls] + 1'b1;
            end
            if (tc_dec) begin
                r_tcnt[r_cls] <= r_tcnt[r_cls] - 1'b1;
            end
            if (wq_push) begin
                r_wtail[r_cls] <= ptr_next(r_wtail[r_cls]);
                r_wcnt[r_cls]  <= r_wcnt[r_cls] + 1'b1;
            end
            if (wq_pop) begin
                r_whead[r_cls] <= ptr_next(r_whead[r_cls]);
                r_wcnt[r_cls]  <= r_wcnt[r_cls] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_act <= i_action;
            r_cls <= CLW'(i_group_size - 3'd1);
            r_rid <= i_resource_id;
            r_tkt <= i_ticket;
        end
        r_idx  <= n_idx;
        r_base <= n_base;
        r_len  <= n_len;
        r_end  <= n_end;
        r_word <= n_word;
        r_res  <= n_res;
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_res.kind;
    assign o_ticket_out = r_res.ticket;
    assign o_granted_id = r_res.id;
    assign o_last       = r_res.last;

    // a non-final result is always the release half of a handoff
    `CPAFW_ASSERT_NEXT(a_handoff_pair, i_clk, i_rst_n, r_ovalid && !r_res.last,
        r_ovalid && r_res.last && r_res.kind == KIND_GRANTED, "handoff grant missing")
    `CPAFW_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, r_ovalid && r_res.last,
        r_state == S_IDLE, "final result while still busy")
    `CPAFW_ASSERT_NOW(a_taken_bound, i_clk, i_rst_n, r_state == S_DECIDE,
        r_tcnt[r_cls] <= r_len, "taken count above class length")
    `CPAFW_ASSERT_NOW(a_wait_bound, i_clk, i_rst_n, r_state == S_QUEUE,
        r_wcnt[r_cls] <= WCW'(WAIT_DEPTH), "wait count above fifo depth")
    `CPAFW_ASSERT_NEXT(a_cfg_clear, i_clk, i_rst_n, clr_all,
        busy && !r_ovalid, "register write did not start clearing")

endmodule
